@@ sv/kfper_pkg.sv @@
package kfper_pkg;

	localparam int FRAME_LEN    = 7;
	localparam int RING_DEPTH   = 16;
	localparam int BUTTON_COUNT = 14;

	localparam int IDX_W   = $clog2(FRAME_LEN);
	localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W  = $clog2(RING_DEPTH + 1);
	localparam int SCAN_W  = $clog2(BUTTON_COUNT);
	localparam int ENTRY_W = 5;
	localparam int PEND_W  = 5;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 96;

	localparam logic [7:0] SYNC_FIRST  = 8'hBD;
	localparam logic [7:0] SYNC_SECOND = 8'h1D;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_SYNC2   = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PARSE,
		ST_POP,
		ST_SCAN,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic parse;
		logic pop;
		logic scan;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_scan;
		logic scan_last;
	} dp_status_t;

	function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(RING_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

endpackage

@@ sv/kfper_ctrl.sv @@
module kfper_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_func,
	input  logic                   out_ready,
	input  kfper_pkg::dp_status_t  status,
	output logic                   in_ready,
	output logic                   out_valid,
	output kfper_pkg::ctrl_cmd_t   cmd,
	output kfper_pkg::ctrl_state_t state
);
	import kfper_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_func ? ST_POP : ST_PARSE;
				end
			end
			ST_PARSE: begin
				cmd.parse = 1'b1;
				state_d   = status.start_scan ? ST_SCAN : ST_FINISH;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result register frees up in the same cycle its beat is taken.
				if (!out_vld_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;
	assign state     = state_q;

endmodule

@@ sv/kfper_dp.sv @@
module kfper_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take,
	input  logic [kfper_pkg::IN_DATA_W-1:0]      in_byte,
	input  kfper_pkg::ctrl_cmd_t                 cmd,
	output kfper_pkg::dp_status_t                status,
	output logic [kfper_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                                 out_event_valid
);
	import kfper_pkg::*;

	logic [7:0]              byte_q;
	phase_t                  phase_q;
	logic [IDX_W-1:0]        idx_q;
	logic [7:0]              sum_q;
	logic [7:0]              b2_q, b3_q, b4_q, b5_q;
	logic                    primed_q;
	logic [BUTTON_COUNT-1:0] held_q;
	logic [2:0]              flags_q;
	logic [31:0]             good_q;
	logic [31:0]             bad_q;
	logic [BUTTON_COUNT-1:0] changed_q;
	logic [SCAN_W-1:0]       scan_q;
	logic [PTR_W-1:0]        head_q;
	logic [PTR_W-1:0]        tail_q;
	logic [FILL_W-1:0]       fill_q;
	logic                    ev_valid_q;
	logic [3:0]              ev_button_q;
	logic                    ev_pressed_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_user_q;

	logic [ENTRY_W-1:0]      ring_mem [RING_DEPTH];

	logic [BUTTON_COUNT-1:0] new_buttons;
	logic [2:0]              new_flags;
	logic                    last_byte;
	logic                    sum_ok;
	logic                    push;

	always_comb begin
		new_buttons = {b5_q[2:0], b4_q[7], b3_q[5], b3_q[4], b3_q[3], b3_q[0], b2_q[5:0]};
		new_flags   = {b4_q[2], b3_q[1], b3_q[2]};
		last_byte   = (phase_q == PH_COLLECT) && (idx_q == IDX_W'(FRAME_LEN - 1));
		sum_ok      = (sum_q == byte_q);
		push        = cmd.scan && changed_q[scan_q];
		status.start_scan = last_byte && sum_ok && primed_q;
		status.scan_last  = (scan_q == SCAN_W'(BUTTON_COUNT - 1));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[tail_q] <= {held_q[scan_q], 4'(scan_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= in_byte;
		end
		if (cmd.parse && phase_q == PH_COLLECT && !last_byte) begin
			if (idx_q == IDX_W'(2)) b2_q <= byte_q;
			if (idx_q == IDX_W'(3)) b3_q <= byte_q;
			if (idx_q == IDX_W'(4)) b4_q <= byte_q;
			if (idx_q == IDX_W'(5)) b5_q <= byte_q;
		end
		if (cmd.parse) begin
			ev_valid_q   <= 1'b0;
			ev_button_q  <= '0;
			ev_pressed_q <= 1'b0;
		end else if (cmd.pop) begin
			if (fill_q != '0) begin
				ev_valid_q   <= 1'b1;
				ev_button_q  <= ring_mem[head_q][3:0];
				ev_pressed_q <= ring_mem[head_q][4];
			end else begin
				ev_valid_q   <= 1'b0;
				ev_button_q  <= '0;
				ev_pressed_q <= 1'b0;
			end
		end
		if (cmd.load_out) begin
			out_user_q <= ev_valid_q;
			out_data_q <= {5'd0, PEND_W'(fill_q), bad_q, good_q, flags_q, held_q,
				ev_pressed_q, ev_button_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			idx_q     <= '0;
			sum_q     <= '0;
			primed_q  <= 1'b0;
			held_q    <= '0;
			flags_q   <= '0;
			good_q    <= '0;
			bad_q     <= '0;
			changed_q <= '0;
			scan_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
		end else begin
			if (cmd.parse) begin
				scan_q <= '0;
				case (phase_q)
					PH_HUNT: begin
						if (byte_q == SYNC_FIRST) begin
							sum_q   <= SYNC_FIRST;
							idx_q   <= IDX_W'(1);
							phase_q <= PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						if (byte_q == SYNC_SECOND) begin
							sum_q   <= sum_q + byte_q;
							idx_q   <= IDX_W'(2);
							phase_q <= PH_COLLECT;
						end else begin
							bad_q <= bad_q + 32'd1;
							// A second sync-first byte restarts the pair.
							if (byte_q == SYNC_FIRST) begin
								sum_q <= SYNC_FIRST;
								idx_q <= IDX_W'(1);
							end else begin
								phase_q <= PH_HUNT;
							end
						end
					end
					PH_COLLECT: begin
						if (last_byte) begin
							phase_q <= PH_HUNT;
							idx_q   <= '0;
							if (!sum_ok) begin
								bad_q <= bad_q + 32'd1;
							end else begin
								good_q    <= good_q + 32'd1;
								flags_q   <= new_flags;
								held_q    <= new_buttons;
								primed_q  <= 1'b1;
								changed_q <= new_buttons ^ held_q;
							end
						end else begin
							sum_q <= sum_q + byte_q;
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
			if (cmd.scan) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
			if (push) begin
				tail_q <= ring_inc(tail_q);
				// A full ring drops its oldest entry to make room.
				if (fill_q == FILL_W'(RING_DEPTH)) begin
					head_q <= ring_inc(head_q);
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end else if (cmd.pop && fill_q != '0) begin
				head_q <= ring_inc(head_q);
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	assign out_data        = out_data_q;
	assign out_event_valid = out_user_q;

endmodule

@@ sv/keypad_frame_parser_event_ring_top.sv @@
// Keypad frame parser with a button event ring. Each input beat carries either a received
// UART byte (tuser = 0) or a request to pop the oldest button event (tuser = 1), and each
// one yields exactly one output beat holding the popped event, the current buttons and
// flags, the good-frame and error counters, and the ring fill. One item at a time is worked
// on: a byte or a pop passes through a parse or pop state and then a finish state, where it
// is loaded into the result register, and the next beat is taken only back in the idle state.
// The byte that closes a good frame after the first also passes through a scan state,
// because a sequencer walks the fourteen buttons one per cycle and pushes a press or
// release event for each one that changed. A result still waiting at the output holds the
// next one back in its last cycle until the waiting beat is taken. A full ring drops its
// oldest event on a push. The next input beat is taken while a result still waits at the
// output.
module keypad_frame_parser_event_ring_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [kfper_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // byte_value
	input  logic                                 s_axis_tuser,  // func
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// event_button, event_pressed, button_state, status_flags, frame_total,
	// error_total, pending_events, zero fill
	output logic [kfper_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tuser   // event_valid
);
	import kfper_pkg::*;

	ctrl_cmd_t   cmd;
	dp_status_t  status;
	ctrl_state_t state;
	logic        take;

	assign take = s_axis_tvalid && s_axis_tready;

	kfper_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_func   (s_axis_tuser),
		.out_ready (m_axis_tready),
		.status    (status),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd),
		.state     (state)
	);

	kfper_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.in_byte         (s_axis_tdata),
		.cmd             (cmd),
		.status          (status),
		.out_data        (m_axis_tdata),
		.out_event_valid (m_axis_tuser)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_axis_tready)
		else $error("input accepted while an item is still in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[90:86] <= 5'(RING_DEPTH)))
		else $error("ring fill beyond its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[3:0] < 4'(BUTTON_COUNT)))
		else $error("popped event names a button that does not exist");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_SCAN && status.scan_last) |=> (state == ST_FINISH))
		else $error("button scan did not end after the last button");

endmodule

@@ test/keypad_frame_parser_event_ring_top_test.sv @@
module keypad_frame_parser_event_ring_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kfper_pkg::*;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct {
		logic        func;
		logic [7:0]  value;
	} keypad_beat_t;

	typedef struct {
		logic        event_valid;
		logic [3:0]  event_button;
		logic        event_pressed;
		logic [13:0] button_state;
		logic [2:0]  status_flags;
		logic [31:0] frame_total;
		logic [31:0] error_total;
		logic [4:0]  pending_events;
	} keypad_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = FUNC_BYTE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	keypad_beat_t   pending_beats[$];
	keypad_report_t expected_reports[$];
	int             mismatch_count = 0;
	int             beats_planned = 0;

	// Shadow of the parser and the event ring.
	phase_t      parse_ph = PH_HUNT;
	int unsigned frame_pos = 0;
	logic [7:0]  frame_bytes[FRAME_LEN];
	bit          seen_first_frame = 0;
	logic [13:0] held_buttons = '0;
	logic [2:0]  held_flags = '0;
	logic [31:0] good_count = '0;
	logic [31:0] error_count = '0;
	logic [4:0]  event_slots[RING_DEPTH];
	int unsigned ring_rd = 0;
	int unsigned ring_used = 0;

	keypad_frame_parser_event_ring_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_button_event(int unsigned button, logic pressed);
		int unsigned slot;
		if (ring_used >= RING_DEPTH) begin
			ring_rd = (ring_rd + 1) % RING_DEPTH;
			ring_used = RING_DEPTH - 1;
		end
		slot = (ring_rd + ring_used) % RING_DEPTH;
		event_slots[slot] = {pressed, 4'(button)};
		ring_used++;
	endfunction

	function automatic void close_frame();
		logic [7:0]  sum;
		logic [13:0] fresh;
		logic [13:0] changed;
		sum = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += frame_bytes[i];
		if (sum != frame_bytes[FRAME_LEN-1]) begin
			error_count++;
			return;
		end
		good_count++;
		held_flags = {frame_bytes[4][2], frame_bytes[3][1], frame_bytes[3][2]};
		fresh = {frame_bytes[5][2:0], frame_bytes[4][7], frame_bytes[3][5], frame_bytes[3][4],
			frame_bytes[3][3], frame_bytes[3][0], frame_bytes[2][5:0]};
		if (seen_first_frame) begin
			changed = fresh ^ held_buttons;
			for (int i = 0; i < BUTTON_COUNT; i++)
				if (changed[i])
					push_button_event(i, fresh[i]);
		end
		seen_first_frame = 1;
		held_buttons = fresh;
	endfunction

	function automatic void predict_report(logic func, logic [7:0] value);
		keypad_report_t rep;
		rep.event_valid   = 1'b0;
		rep.event_button  = '0;
		rep.event_pressed = 1'b0;
		if (func == FUNC_BYTE) begin
			case (parse_ph)
				PH_HUNT: begin
					if (value == SYNC_FIRST) begin
						frame_bytes[0] = value;
						frame_pos = 1;
						parse_ph = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (value == SYNC_SECOND) begin
						frame_bytes[1] = value;
						frame_pos = 2;
						parse_ph = PH_COLLECT;
					end else begin
						error_count++;
						if (value == SYNC_FIRST) begin
							frame_bytes[0] = value;
							frame_pos = 1;
						end else begin
							parse_ph = PH_HUNT;
						end
					end
				end
				default: begin
					frame_bytes[frame_pos] = value;
					frame_pos++;
					if (frame_pos >= FRAME_LEN) begin
						parse_ph = PH_HUNT;
						frame_pos = 0;
						close_frame();
					end
				end
			endcase
		end else if (ring_used > 0) begin
			rep.event_valid   = 1'b1;
			rep.event_button  = event_slots[ring_rd][3:0];
			rep.event_pressed = event_slots[ring_rd][4];
			ring_rd = (ring_rd + 1) % RING_DEPTH;
			ring_used--;
		end
		rep.button_state   = held_buttons;
		rep.status_flags   = held_flags;
		rep.frame_total    = good_count;
		rep.error_total    = error_count;
		rep.pending_events = 5'(ring_used);
		expected_reports.push_back(rep);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic queue_beat(logic func, logic [7:0] value);
		keypad_beat_t b;
		b.func  = func;
		b.value = value;
		pending_beats.push_back(b);
	endtask

	// Sync pair, four body bytes, then the checksum. A nonzero skew corrupts the sum.
	task automatic queue_frame(logic [7:0] b2, logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
			logic [7:0] skew);
		logic [7:0] sum;
		sum = SYNC_FIRST + SYNC_SECOND + b2 + b3 + b4 + b5;
		queue_beat(FUNC_BYTE, SYNC_FIRST);
		queue_beat(FUNC_BYTE, SYNC_SECOND);
		queue_beat(FUNC_BYTE, b2);
		queue_beat(FUNC_BYTE, b3);
		queue_beat(FUNC_BYTE, b4);
		queue_beat(FUNC_BYTE, b5);
		queue_beat(FUNC_BYTE, sum + skew);
		beats_planned += FRAME_LEN;
	endtask

	task automatic queue_pops(int count);
		for (int i = 0; i < count; i++)
			queue_beat(FUNC_POP, 8'($urandom));
		beats_planned += count;
	endtask

	task automatic build_stimulus();
		int pick;
		int n;
		// Pop on an empty ring, then a sync miss that drops back to hunting.
		queue_pops(1);
		queue_beat(FUNC_BYTE, SYNC_FIRST);
		queue_beat(FUNC_BYTE, 8'h00);
		// A repeated first sync byte restarts the sync; the first good frame sets everything.
		queue_beat(FUNC_BYTE, SYNC_FIRST);
		beats_planned += 3;
		queue_frame(8'h3F, 8'h3F, 8'hFF, 8'h07, 8'h00);
		queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
		// Every button is released at once.
		queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_pops(3);

		while (beats_planned < 450) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00);
			end else if (pick < 63) begin
				queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom_range(1, 255)));
			end else if (pick < 68) begin
				queue_beat(FUNC_BYTE, SYNC_FIRST);
				queue_beat(FUNC_BYTE, ($urandom_range(0, 1) == 0) ? SYNC_FIRST : 8'h1C);
				beats_planned += 2;
			end else if (pick < 73) begin
				// Line noise; most of it is ignored while hunting.
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					queue_beat(FUNC_BYTE, 8'($urandom));
				beats_planned += n;
			end else if (pick < 93) begin
				queue_pops($urandom_range(1, 6));
			end else begin
				queue_pops($urandom_range(17, 22));
			end
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		keypad_beat_t b;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_report(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					b = pending_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= b.value;
					s_axis_tuser  <= b.func;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switches between stall patterns every so often.
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	always @(posedge clk) begin
		keypad_report_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					$error("result beat arrived with no prediction waiting");
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("event_valid", 32'(want.event_valid), 32'(m_axis_tuser));
					check_field("event_button", 32'(want.event_button),
						32'(m_axis_tdata[3:0]));
					check_field("event_pressed", 32'(want.event_pressed),
						32'(m_axis_tdata[4]));
					check_field("button_state", 32'(want.button_state),
						32'(m_axis_tdata[18:5]));
					check_field("status_flags", 32'(want.status_flags),
						32'(m_axis_tdata[21:19]));
					check_field("frame_total", want.frame_total, m_axis_tdata[53:22]);
					check_field("error_total", want.error_total, m_axis_tdata[85:54]);
					check_field("pending_events", 32'(want.pending_events),
						32'(m_axis_tdata[90:86]));
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= 1'($urandom);
				2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
				default: m_axis_tready <= (stall_tick % 5 == 0);
			endcase
		end
	end

	initial begin
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_beats.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$error("run timed out");
		$display("Mismatches found");
		$finish;
	end

endmodule
